@@ rtl/cweb_pkg.sv @@
// Shared types, constants and helpers of the coincidence window event builder.
// No dependencies; every other file of the block imports this package.

package cweb_pkg;

  // Event geometry
  localparam int unsigned SLOT_COUNT  = 15;
  localparam int unsigned SLOT_BITS   = 4;
  localparam int unsigned SLOT_WIDE   = 5;
  localparam int unsigned WINDOW_BITS = 32;

  // Default payload widths
  localparam int unsigned DEF_TIME_BITS   = 48;
  localparam int unsigned DEF_ENERGY_BITS = 16;

  // Window register value after reset
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd1000;

  // Slot mapping constants
  localparam logic [2:0]           ANODE_CHANNEL = 3'd4;
  localparam logic [SLOT_WIDE-1:0] ANODE_BASE    = 5'd12;

  // Item function codes
  localparam logic FUNC_HIT   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted item
    logic calc;         // register time difference and stored slot content
    logic put;          // write item into its slot
    logic set_ref;      // take item time as reference
    logic start_close;  // move present mask to the readout mask
    logic emit;         // load lowest pending slot into the output register
  } cweb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic hit_ok;
    logic mask_empty;
    logic in_window;
    logic replace;
    logic out_free;
    logic last_pick;
  } cweb_sts_t;

  // Map plane index and channel to a slot; values of SLOT_COUNT and up are unused
  function automatic logic [SLOT_WIDE-1:0] slot_of(input logic [1:0] idx,
                                                   input logic [2:0] chan);
    logic [SLOT_WIDE-1:0] s;
    if (chan == ANODE_CHANNEL) begin
      s = {3'b000, idx} + ANODE_BASE;
    end else begin
      s = {1'b0, idx, 2'b00} + {2'b00, chan};
    end
    return s;
  endfunction

endpackage

@@ rtl/cweb_if.sv @@
// Valid/ready channel interfaces of the event builder: hit input and slot result.
// Depends on cweb_pkg for the slot field widths.

interface cweb_hit_if #(
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned ENERGY_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic                   hit_valid;
  logic [1:0]             detector_index;
  logic [2:0]             signal_channel;
  logic [TIME_BITS-1:0]   hit_time;
  logic [ENERGY_BITS-1:0] hit_energy;

  modport source (
    output valid, func, hit_valid, detector_index, signal_channel, hit_time, hit_energy,
    input  ready
  );
  modport sink (
    input  valid, func, hit_valid, detector_index, signal_channel, hit_time, hit_energy,
    output ready
  );
endinterface

interface cweb_slot_if #(
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned ENERGY_BITS = 16
);
  import cweb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SLOT_BITS-1:0]   slot_number;
  logic [TIME_BITS-1:0]   slot_time;
  logic [ENERGY_BITS-1:0] slot_energy;
  logic [SLOT_COUNT-1:0]  event_mask;
  logic                   last_of_event;

  modport source (
    output valid, slot_number, slot_time, slot_energy, event_mask, last_of_event,
    input  ready
  );
  modport sink (
    input  valid, slot_number, slot_time, slot_energy, event_mask, last_of_event,
    output ready
  );
endinterface

@@ rtl/cweb_dp.sv @@
// Datapath of the event builder: item latch, window compare, slot store,
// readout scan and output register. Depends on cweb_pkg and cweb_if.

module cweb_dp #(
  parameter int unsigned TIME_BITS   = cweb_pkg::DEF_TIME_BITS,
  parameter int unsigned ENERGY_BITS = cweb_pkg::DEF_ENERGY_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cweb_pkg::WINDOW_BITS-1:0]    cfg_wdata_i,
  input  cweb_pkg::cweb_cmd_t                 cmd_i,
  output cweb_pkg::cweb_sts_t                 sts_o,
  cweb_hit_if.sink                            hit_i,
  cweb_slot_if.source                         slot_o
);
  import cweb_pkg::*;

  localparam int unsigned CMP_BITS = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

  // Item latch
  logic                   flush_q;
  logic                   hit_ok_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [ENERGY_BITS-1:0] energy_q;

  // Event state
  logic [SLOT_COUNT-1:0]  mask_q;
  logic [TIME_BITS-1:0]   ref_q;
  logic [WINDOW_BITS-1:0] window_q;
  logic [SLOT_COUNT-1:0]  pending_q;
  logic [SLOT_COUNT-1:0]  event_mask_q;
  logic [TIME_BITS-1:0]   time_mem_q   [SLOT_COUNT];
  logic [ENERGY_BITS-1:0] energy_mem_q [SLOT_COUNT];

  // Decision inputs
  logic [TIME_BITS-1:0]   diff_q;
  logic                   present_q;
  logic [ENERGY_BITS-1:0] stored_e_q;

  // Output register
  logic                   out_valid_q;
  logic [SLOT_BITS-1:0]   out_slot_q;
  logic [TIME_BITS-1:0]   out_time_q;
  logic [ENERGY_BITS-1:0] out_energy_q;
  logic [SLOT_COUNT-1:0]  out_mask_q;
  logic                   out_last_q;

  logic [SLOT_WIDE-1:0]   slot_wide;
  logic [SLOT_BITS-1:0]   pick;
  logic [SLOT_BITS-1:0]   rd_addr;
  logic                   out_free;
  logic [SLOT_COUNT-1:0]  pick_bit;

  assign slot_wide = slot_of(hit_i.detector_index, hit_i.signal_channel);

  // Lowest pending slot of the readout
  always_comb begin
    pick = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        pick = SLOT_BITS'(i);
      end
    end
  end

  assign pick_bit = SLOT_COUNT'(1) << pick;
  assign rd_addr  = cmd_i.calc ? slot_q : pick;
  assign out_free = !out_valid_q || slot_o.ready;

  // Status toward the controller
  always_comb begin
    sts_o.is_flush   = flush_q;
    sts_o.hit_ok     = hit_ok_q;
    sts_o.mask_empty = (mask_q == '0);
    sts_o.in_window  = CMP_BITS'(diff_q) < CMP_BITS'(window_q);
    sts_o.replace    = !present_q || (energy_q > stored_e_q);
    sts_o.out_free   = out_free;
    sts_o.last_pick  = ((pending_q & (pending_q - SLOT_COUNT'(1))) == '0);
  end

  // Latch item on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      flush_q  <= (hit_i.func == FUNC_FLUSH);
      hit_ok_q <= hit_i.hit_valid && (slot_wide < SLOT_WIDE'(SLOT_COUNT));
      slot_q   <= slot_wide[SLOT_BITS-1:0];
      time_q   <= hit_i.hit_time;
      energy_q <= hit_i.hit_energy;
    end
  end

  // Absolute time difference and slot content for the decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      diff_q     <= (time_q >= ref_q) ? (time_q - ref_q) : (ref_q - time_q);
      present_q  <= mask_q[slot_q];
      stored_e_q <= energy_mem_q[rd_addr];
    end
  end

  // Window register, present mask, reference and readout mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RESET;
      mask_q    <= '0;
      ref_q     <= '0;
      pending_q <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.start_close) begin
        pending_q <= mask_q;
        mask_q    <= '0;
      end else if (cmd_i.put) begin
        mask_q[slot_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        pending_q <= pending_q & ~pick_bit;
      end
      if (cmd_i.set_ref) begin
        ref_q <= time_q;
      end
    end
  end

  // Mask snapshot of the event under readout
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_close) begin
      event_mask_q <= mask_q;
    end
  end

  // Slot store
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      time_mem_q[slot_q]   <= time_q;
      energy_mem_q[slot_q] <= energy_q;
    end
  end

  // Output register: load on emit, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (slot_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_q   <= pick;
      out_time_q   <= time_mem_q[rd_addr];
      out_energy_q <= energy_mem_q[rd_addr];
      out_mask_q   <= event_mask_q;
      out_last_q   <= ((pending_q & ~pick_bit) == '0);
    end
  end

  assign slot_o.valid         = out_valid_q;
  assign slot_o.slot_number   = out_slot_q;
  assign slot_o.slot_time     = out_time_q;
  assign slot_o.slot_energy   = out_energy_q;
  assign slot_o.event_mask    = out_mask_q;
  assign slot_o.last_of_event = out_last_q;

endmodule

@@ rtl/cweb_ctrl.sv @@
// Controller of the event builder: sequences accept, difference, decision and
// event readout. Depends on cweb_pkg for the command and status structs.

module cweb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cweb_pkg::cweb_sts_t sts_i,
  output cweb_pkg::cweb_cmd_t cmd_o
);
  import cweb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CALC   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_CLOSE  = 4'b1000
  } cweb_state_e;

  cweb_state_e state_q, state_d;
  logic        reopen_q, reopen_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    reopen_d   = reopen_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (sts_i.is_flush) begin
          if (!sts_i.mask_empty) begin
            cmd_o.start_close = 1'b1;
            reopen_d          = 1'b0;
            state_d           = ST_CLOSE;
          end
        end else if (sts_i.hit_ok) begin
          if (sts_i.mask_empty) begin
            // open a new event
            cmd_o.put     = 1'b1;
            cmd_o.set_ref = 1'b1;
          end else if (sts_i.in_window) begin
            cmd_o.put = sts_i.replace;
          end else begin
            // close, then open with this hit
            cmd_o.start_close = 1'b1;
            reopen_d          = 1'b1;
            state_d           = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_pick) begin
            cmd_o.put     = reopen_q;
            cmd_o.set_ref = reopen_q;
            state_d       = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      reopen_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      reopen_q <= reopen_d;
    end
  end

endmodule

@@ rtl/coincidence_window_event_builder.sv @@
// Coincidence window event builder, top level. A hit or flush is taken in one
// beat; the block is ready again after the accept, difference and decide steps.
// A closing item then reads out each filled slot in turn, and an output stall
// holds the readout. The output register lets the next item in while the last
// result waits. Reset clears the event, reference time and output, and sets
// the window to 1000 ticks; no clearing pass.

module coincidence_window_event_builder #(
  parameter int unsigned TIME_BITS   = cweb_pkg::DEF_TIME_BITS,
  parameter int unsigned ENERGY_BITS = cweb_pkg::DEF_ENERGY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cweb_pkg::WINDOW_BITS-1:0] cfg_wdata_i,
  cweb_hit_if.sink                         hit_i,
  cweb_slot_if.source                      slot_o
);
  import cweb_pkg::*;

  cweb_cmd_t cmd;
  cweb_sts_t sts;
  logic      in_ready;

  assign hit_i.ready = in_ready;

  // Sequencer
  cweb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (hit_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, compare and output
  cweb_dp #(
    .TIME_BITS   (TIME_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .hit_i       (hit_i),
    .slot_o      (slot_o)
  );

endmodule

@@ rtl/cweb_sva.sv @@
// Port-level checks of the event builder, bound to the top level.
// Depends on cweb_pkg and coincidence_window_event_builder.

module cweb_sva (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cweb_pkg::SLOT_BITS-1:0]      slot_number,
  input logic [cweb_pkg::SLOT_COUNT-1:0]     event_mask,
  input logic                                last_of_event
);
  import cweb_pkg::*;

  // Stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(slot_number)
      && $stable(event_mask) && $stable(last_of_event))
    else $error("result beat changed while stalled");

  // Reported slot is part of its event
  a_slot_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> slot_number < SLOT_BITS'(SLOT_COUNT) && event_mask[slot_number])
    else $error("reported slot not in event mask");

  // Last flag marks exactly the highest slot of the event
  a_last_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> last_of_event == ((event_mask >> slot_number) == SLOT_COUNT'(1)))
    else $error("last flag does not match highest slot");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

endmodule

bind coincidence_window_event_builder cweb_sva u_cweb_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (hit_i.valid),
  .in_ready      (hit_i.ready),
  .out_valid     (slot_o.valid),
  .out_ready     (slot_o.ready),
  .slot_number   (slot_o.slot_number),
  .event_mask    (slot_o.event_mask),
  .last_of_event (slot_o.last_of_event)
);

@@ tb/testbench.sv @@
// Self-checking bench for coincidence_window_event_builder: directed and random hit traffic,
// an internal event predictor and an in-order check of every slot report.
// Depends on cweb_pkg, the cweb_hit_if / cweb_slot_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import cweb_pkg::*;

  localparam int unsigned TIME_W   = DEF_TIME_BITS;
  localparam int unsigned ENERGY_W = DEF_ENERGY_BITS;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int unsigned PLANE_SLOTS    = 4;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic                func;
    logic                hit_valid;
    logic [1:0]          detector_index;
    logic [2:0]          signal_channel;
    logic [TIME_W-1:0]   hit_time;
    logic [ENERGY_W-1:0] hit_energy;
  } hit_beat_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  slot_number;
    logic [TIME_W-1:0]     slot_time;
    logic [ENERGY_W-1:0]   slot_energy;
    logic [SLOT_COUNT-1:0] event_mask;
    logic                  last_of_event;
  } slot_report_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [WINDOW_BITS-1:0] cfg_wdata_i;

  cweb_hit_if  #(.TIME_BITS(TIME_W), .ENERGY_BITS(ENERGY_W)) hit_bus ();
  cweb_slot_if #(.TIME_BITS(TIME_W), .ENERGY_BITS(ENERGY_W)) slot_bus ();

  coincidence_window_event_builder #(
    .TIME_BITS  (TIME_W),
    .ENERGY_BITS(ENERGY_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .hit_i      (hit_bus),
    .slot_o     (slot_bus)
  );

  // Predicted block state
  logic [WINDOW_BITS-1:0] window_q = WINDOW_RESET;
  logic [SLOT_COUNT-1:0]  open_mask = '0;
  logic [TIME_W-1:0]      reference_q = '0;
  logic [TIME_W-1:0]      kept_time [SLOT_COUNT];
  logic [ENERGY_W-1:0]    kept_energy [SLOT_COUNT];

  hit_beat_t    pending_hits [$];
  slot_report_t due_reports [$];

  hit_beat_t   cur_hit;
  bit          drv_busy = 1'b0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned hold_cnt = 0;
  bit          src_quiet = 1'b0;
  bit          snk_quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          failed = 1'b0;
  int unsigned idle_cycles = 0;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (quiet || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Emit one report per filled slot, ascending, and clear the event
  task automatic close_open_event();
    slot_report_t r;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (open_mask[s]) begin
        r.slot_number   = SLOT_BITS'(s);
        r.slot_time     = kept_time[s];
        r.slot_energy   = kept_energy[s];
        r.event_mask    = open_mask;
        r.last_of_event = ((open_mask >> (s + 1)) == '0);
        due_reports.push_back(r);
      end
    end
    open_mask = '0;
  endtask

  task automatic fill_slot(input int unsigned s, input hit_beat_t b);
    open_mask[s]   = 1'b1;
    kept_time[s]   = b.hit_time;
    kept_energy[s] = b.hit_energy;
  endtask

  // Advance the event state by one accepted beat
  task automatic build_event(input hit_beat_t b);
    int unsigned       s;
    logic [TIME_W-1:0] diff;
    if (b.func == FUNC_FLUSH) begin
      close_open_event();
      return;
    end
    if (!b.hit_valid) return;
    if (b.signal_channel == ANODE_CHANNEL) s = b.detector_index + ANODE_BASE;
    else s = b.detector_index * PLANE_SLOTS + b.signal_channel;
    if (s >= SLOT_COUNT) return;
    if (open_mask == '0) begin
      fill_slot(s, b);
      reference_q = b.hit_time;
      return;
    end
    diff = (b.hit_time >= reference_q) ? b.hit_time - reference_q : reference_q - b.hit_time;
    if (diff < {{(TIME_W - WINDOW_BITS){1'b0}}, window_q}) begin
      if (!open_mask[s] || b.hit_energy > kept_energy[s]) fill_slot(s, b);
      return;
    end
    close_open_event();
    fill_slot(s, b);
    reference_q = b.hit_time;
  endtask

  // Hit driver: predict on accept, then offer the next pending beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hit_bus.valid && hit_bus.ready) begin
        build_event(cur_hit);
        drv_busy = 1'b0;
        src_gap  = pick_gap(src_quiet);
      end
      if (!drv_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_hits.size() > 0) begin
          cur_hit = pending_hits.pop_front();
          drv_busy = 1'b1;
          hit_bus.func           <= cur_hit.func;
          hit_bus.hit_valid      <= cur_hit.hit_valid;
          hit_bus.detector_index <= cur_hit.detector_index;
          hit_bus.signal_channel <= cur_hit.signal_channel;
          hit_bus.hit_time       <= cur_hit.hit_time;
          hit_bus.hit_energy     <= cur_hit.hit_energy;
        end
      end
      hit_bus.valid <= drv_busy;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Report monitor: compare each beat with the oldest prediction, drive ready
  always @(posedge clk_i) begin
    slot_report_t want;
    if (rst_ni) begin
      if (slot_bus.valid && slot_bus.ready) begin
        if (due_reports.size() == 0) begin
          $error("slot report beat with nothing predicted: slot %0d", slot_bus.slot_number);
          failed = 1'b1;
        end else begin
          want = due_reports.pop_front();
          check_field("slot_number", want.slot_number, slot_bus.slot_number);
          check_field("slot_time", want.slot_time, slot_bus.slot_time);
          check_field("slot_energy", want.slot_energy, slot_bus.slot_energy);
          check_field("event_mask", want.event_mask, slot_bus.event_mask);
          check_field("last_of_event", want.last_of_event, slot_bus.last_of_event);
        end
        snk_gap = pick_gap(snk_quiet);
      end
      if (hold_req && !hold_done) begin
        hold_cnt  = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        slot_bus.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        slot_bus.ready <= 1'b0;
      end else begin
        slot_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((hit_bus.valid && hit_bus.ready) || (slot_bus.valid && slot_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("coincidence_window_event_builder regression: fail");
      $finish;
    end
  end

  task automatic queue_hit(input logic func, input logic vld, input logic [1:0] idx,
                           input logic [2:0] chan, input logic [TIME_W-1:0] t,
                           input logic [ENERGY_W-1:0] e);
    hit_beat_t b;
    b.func           = func;
    b.hit_valid      = vld;
    b.detector_index = idx;
    b.signal_channel = chan;
    b.hit_time       = t;
    b.hit_energy     = e;
    pending_hits.push_back(b);
  endtask

  function automatic logic [TIME_W-1:0] pick_reference();
    case ($urandom_range(0, 7))
      0:       return TIME_W'($urandom_range(0, 2000));
      1:       return TIME_MAX - TIME_W'($urandom_range(0, 2000));
      default: return TIME_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // Time around the reference, biased to the window edge
  function automatic logic [TIME_W-1:0] near_time(input logic [TIME_W-1:0] base,
                                                  input logic [WINDOW_BITS-1:0] w);
    logic [TIME_W-1:0] off;
    case ($urandom_range(0, 5))
      0:       off = '0;
      1:       off = (w == 0) ? '0 : TIME_W'(w - 1);
      2:       off = TIME_W'(w);
      default: off = (w == 0) ? '0 : TIME_W'($urandom_range(0, w - 1));
    endcase
    if ($urandom_range(0, 1) == 1 && base <= TIME_MAX - off) return base + off;
    if (base >= off) return base - off;
    return base + off;
  endfunction

  // Small energies make equal-energy ties likely
  function automatic logic [ENERGY_W-1:0] pick_energy();
    if ($urandom_range(0, 3) == 0) return ENERGY_W'($urandom_range(0, 3));
    return ENERGY_W'($urandom());
  endfunction

  // Mostly well-formed events with random content, some noise
  task automatic random_traffic(input int n);
    int                count;
    int                hits;
    bit                sweep;
    logic [TIME_W-1:0] base;
    logic [1:0]        idx;
    logic [2:0]        chan;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_hit(($urandom_range(0, 3) == 0) ? FUNC_FLUSH : FUNC_HIT, 1'($urandom()),
                  2'($urandom()), 3'($urandom()), TIME_W'({$urandom(), $urandom()}),
                  ENERGY_W'($urandom()));
        count++;
      end else begin
        base  = pick_reference();
        sweep = ($urandom_range(0, 5) == 0);
        hits  = sweep ? SLOT_COUNT : $urandom_range(1, 12);
        for (int h = 0; h < hits; h++) begin
          if (sweep && h < 12) begin
            idx  = 2'(h / PLANE_SLOTS);
            chan = 3'(h % PLANE_SLOTS);
          end else if (sweep) begin
            idx  = 2'(h - 12);
            chan = ANODE_CHANNEL;
          end else begin
            idx  = 2'($urandom_range(0, 2));
            chan = 3'($urandom_range(0, 4));
          end
          queue_hit(FUNC_HIT, 1'b1, idx, chan, (h == 0) ? base : near_time(base, window_q),
                    pick_energy());
        end
        count += hits;
        if ($urandom_range(0, 2) == 0) begin
          queue_hit(FUNC_FLUSH, 1'($urandom()), 2'($urandom()), 3'($urandom()),
                    TIME_W'({$urandom(), $urandom()}), ENERGY_W'($urandom()));
          count++;
        end
      end
    end
  endtask

  // Wait until every beat is taken and every report is back, then let the block settle
  task automatic drain();
    while (pending_hits.size() != 0 || drv_busy || due_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [WINDOW_BITS-1:0] w);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    window_q = w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reset, directed items, then random phases over several windows
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    hit_bus.valid          = 1'b0;
    hit_bus.func           = FUNC_HIT;
    hit_bus.hit_valid      = 1'b0;
    hit_bus.detector_index = '0;
    hit_bus.signal_channel = '0;
    hit_bus.hit_time       = '0;
    hit_bus.hit_energy     = '0;
    slot_bus.ready         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset window of 1000 ticks
    queue_hit(FUNC_FLUSH, 1'b0, 2'd0, 3'd0, '0, '0);              // flush with no event
    queue_hit(FUNC_HIT, 1'b0, 2'd1, 3'd1, 48'd5, 16'd7);          // invalid hit
    queue_hit(FUNC_HIT, 1'b1, 2'd3, 3'd4, 48'd9, 16'd9);          // slot out of range
    queue_hit(FUNC_HIT, 1'b1, 2'd2, 3'd7, 48'd9, 16'd9);          // slot out of range
    queue_hit(FUNC_HIT, 1'b1, 2'd0, 3'd0, 48'd2000, 16'd100);     // open event
    queue_hit(FUNC_HIT, 1'b1, 2'd0, 3'd0, 48'd2500, 16'd100);     // equal energy, keep
    queue_hit(FUNC_HIT, 1'b1, 2'd0, 3'd0, 48'd1500, 16'd101);     // larger energy, replace
    queue_hit(FUNC_HIT, 1'b1, 2'd2, 3'd4, 48'd2999, 16'hFFFF);    // anode slot, inside edge
    queue_hit(FUNC_HIT, 1'b1, 2'd3, 3'd0, 48'd1001, 16'd0);       // earlier time, inside edge
    queue_hit(FUNC_FLUSH, 1'b0, 2'd3, 3'd7, TIME_MAX, 16'hFFFF);  // flush ignores operands
    queue_hit(FUNC_FLUSH, 1'b1, 2'd1, 3'd2, 48'd0, 16'd0);        // flush after close
    queue_hit(FUNC_HIT, 1'b1, 2'd1, 3'd3, TIME_MAX, 16'd1);       // open at top time
    queue_hit(FUNC_HIT, 1'b1, 2'd0, 3'd1, TIME_MAX - 48'd1000, 16'd2); // on the edge, close
    queue_hit(FUNC_HIT, 1'b1, 2'd1, 3'd2, 48'd0, 16'hFFFF);       // far away, close
    queue_hit(FUNC_HIT, 1'b1, 2'd2, 3'd4, 48'd999, 16'd0);
    queue_hit(FUNC_HIT, 1'b1, 2'd1, 3'd2, 48'd0, 16'd0);          // smaller energy, keep
    queue_hit(FUNC_FLUSH, 1'b0, 2'd0, 3'd0, '0, '0);
    random_traffic(55);

    // Zero window: every valid in-range hit closes the open event
    set_window('0);
    random_traffic(55);

    // Widest window, with a long receiver hold-off while hits keep coming
    set_window('1);
    hold_req = 1'b1;
    random_traffic(70);

    // Narrowest nonzero window, no idling on either side
    set_window(32'd1);
    src_quiet = 1'b1;
    snk_quiet = 1'b1;
    random_traffic(55);

    set_window(WINDOW_BITS'($urandom_range(2, 100000)));
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
    random_traffic(55);

    set_window(WINDOW_RESET);
    random_traffic(55);
    queue_hit(FUNC_FLUSH, 1'b0, 2'd0, 3'd0, '0, '0);

    drain();
    if (!failed && due_reports.size() == 0) begin
      $display("coincidence_window_event_builder regression: pass");
    end else begin
      $display("coincidence_window_event_builder regression: fail");
    end
    $finish;
  end

endmodule
